// File: rtl/core/pcmsfc_pkg.sv
// ----------------------------------------------------------------------------
// PCM sample format converter package
// Shared word types, format codes and the float conversion helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcmsfc_pkg;

   typedef enum logic [3:0] {
      FMT_U8    = 4'd0,
      FMT_I8    = 4'd1,
      FMT_I16LE = 4'd2,
      FMT_I16BE = 4'd3,
      FMT_I24LE = 4'd4,
      FMT_I24BE = 4'd5,
      FMT_I32LE = 4'd6,
      FMT_I32BE = 4'd7,
      FMT_F32   = 4'd8,
      FMT_F64   = 4'd9
   } fmt_type;

   localparam int unsigned FMT_W = 4;
   localparam int unsigned REG_FORMAT = 0;
   localparam logic [FMT_W-1:0] FORMAT_RESET = 4'd0;

   typedef struct packed {
      logic [63:0] raw_word;
      logic        channel_in;
      logic        last_in;
   } req_word_type;

   typedef struct packed {
      logic [31:0] sample_value;
      logic        is_float;
      logic        channel_out;
      logic        last_out;
   } rsp_word_type;

   // Signed integer scaled by 2^-scale, rounded to float32 nearest even.
   function automatic logic [31:0] int_to_float(input logic [31:0] v,
                                                input logic [7:0] scale);
      logic        s;
      logic [31:0] mag;
      logic [4:0]  p;
      logic [31:0] norm;
      logic [24:0] mant;
      logic        rb;
      logic        st;
      logic [7:0]  ex;
      s = v[31];
      mag = s ? (32'd0 - v) : v;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) begin
            p = 5'(i);
         end
      end
      norm = mag << (5'd31 - p);
      mant = {1'b0, norm[31:8]};
      rb = norm[7];
      st = |norm[6:0];
      if (rb && (st || norm[8])) begin
         mant = mant + 25'd1;
      end
      ex = 8'd127 + {3'd0, p} - scale;
      if (mant[24]) begin
         ex = ex + 8'd1;
      end
      if (mag == 32'd0) begin
         int_to_float = 32'd0;
      end else begin
         int_to_float = {s, ex, (mant[24] ? mant[23:1] : mant[22:0])};
      end
   endfunction

   // float64 to float32, IEEE round to nearest even.
   function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
      logic        s;
      logic [10:0] e;
      logic [52:0] m;
      logic [12:0] ef;
      logic [24:0] mant;
      logic [7:0]  sh;
      logic [53:0] den;
      logic [52:0] q;
      logic        half;
      logic        st;
      s = d[63];
      e = d[62:52];
      m = {1'b1, d[51:0]};
      ef = {2'd0, e} - 13'd896;
      f64_to_f32 = {s, 31'd0};
      if (e == 11'h7ff) begin
         if (d[51:0] == 52'd0) begin
            f64_to_f32 = {s, 8'hff, 23'd0};
         end else begin
            f64_to_f32 = {s, 9'h1ff, d[50:29]};
         end
      end else if (e == 11'd0) begin
         f64_to_f32 = {s, 31'd0};
      end else if (!ef[12] && ef >= 13'd255) begin
         f64_to_f32 = {s, 8'hff, 23'd0};
      end else if (!ef[12] && ef != 13'd0) begin
         mant = {1'b0, m[52:29]};
         if (m[28] && ((|m[27:0]) || m[29])) begin
            mant = mant + 25'd1;
         end
         if (mant[24]) begin
            if (ef[7:0] == 8'd254) begin
               f64_to_f32 = {s, 8'hff, 23'd0};
            end else begin
               f64_to_f32 = {s, ef[7:0] + 8'd1, mant[23:1]};
            end
         end else begin
            f64_to_f32 = {s, ef[7:0], mant[22:0]};
         end
      end else begin
         // Subnormal target: shift = 30 - ef, result zero once shift >= 64.
         if (ef[12] && (13'd0 - ef) > 13'd33) begin
            f64_to_f32 = {s, 31'd0};
         end else begin
            sh = 8'(13'd30 - ef);
            den = {m, 1'b0} >> sh;
            q = den[53:1];
            half = den[0];
            st = ((m << (8'd54 - sh)) & {53{1'b1}}) != 53'd0;
            if (half && (st || q[0])) begin
               q = q + 53'd1;
            end
            f64_to_f32 = {s, q[30:0]};
         end
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcmsfc_convert.sv
// ----------------------------------------------------------------------------
// PCM sample converter datapath
// Byte selection and the integer and float conversions for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcmsfc_convert
   import pcmsfc_pkg::*;
(
   input  wire logic [FMT_W-1:0] fmt,
   input  wire req_word_type     req,
   output rsp_word_type          rsp
);

   logic [7:0]  b0, b1, b2, b3;
   logic [31:0] v24le, v24be, v32le, v32be;

   assign b0 = req.raw_word[7:0];
   assign b1 = req.raw_word[15:8];
   assign b2 = req.raw_word[23:16];
   assign b3 = req.raw_word[31:24];
   assign v24le = {{8{b2[7]}}, b2, b1, b0};
   assign v24be = {{8{b0[7]}}, b0, b1, b2};
   assign v32le = {b3, b2, b1, b0};
   assign v32be = {b0, b1, b2, b3};

   always_comb begin
      rsp.channel_out = req.channel_in;
      rsp.last_out = req.last_in;
      rsp.sample_value = 32'd0;
      rsp.is_float = 1'b0;
      unique case (fmt)
         FMT_U8:    rsp.sample_value = {16'd0, ~b0[7], b0[6:0], 8'd0};
         FMT_I8:    rsp.sample_value = {16'd0, b0, 8'd0};
         FMT_I16LE: rsp.sample_value = {16'd0, b1, b0};
         FMT_I16BE: rsp.sample_value = {16'd0, b0, b1};
         FMT_I24LE: begin
            rsp.sample_value = int_to_float(v24le, 8'd23);
            rsp.is_float = 1'b1;
         end
         FMT_I24BE: begin
            rsp.sample_value = int_to_float(v24be, 8'd23);
            rsp.is_float = 1'b1;
         end
         FMT_I32LE: begin
            rsp.sample_value = int_to_float(v32le, 8'd31);
            rsp.is_float = 1'b1;
         end
         FMT_I32BE: begin
            rsp.sample_value = int_to_float(v32be, 8'd31);
            rsp.is_float = 1'b1;
         end
         FMT_F32: begin
            rsp.sample_value = req.raw_word[31:0];
            rsp.is_float = 1'b1;
         end
         FMT_F64: begin
            rsp.sample_value = f64_to_f32(req.raw_word);
            rsp.is_float = 1'b1;
         end
         default: begin
            rsp.sample_value = 32'd0;
            rsp.is_float = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/pcm_sample_format_converter_top.sv
// ----------------------------------------------------------------------------
// PCM sample format converter
// Turns one raw audio word into an int16 or float32 sample per cycle.
//
//   channel   direction  handshake                     payload
//   req_      in         start & !busy                 req_word_type
//   rsp_      out        rsp_strobe, one cycle         rsp_word_type
//   csr_      in/out     APB write on psel&penable     format register
//
// One word is taken every cycle; busy is always low.
// Each started word passes through an input register, then the converter
// logic into the result register.
// Reset clears the format register to unsigned 8-bit and drops all strobes.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcm_sample_format_converter_top
   import pcmsfc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_word_type req_word,
   output logic              rsp_strobe,
   output rsp_word_type      rsp_word,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [1:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [FMT_W-1:0] fmt_ff, fmt_in;
   logic             req_valid_ff;
   req_word_type     req_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_ff, rsp_in;

   assign busy = 1'b0;
   assign pready = 1'b1;
   assign prdata = (paddr == 2'(REG_FORMAT * 4)) ? {28'd0, fmt_ff} : 32'd0;

   always_comb begin
      fmt_in = fmt_ff;
      if (psel && penable && pwrite && paddr == 2'(REG_FORMAT * 4)) begin
         fmt_in = pwdata[FMT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FORMAT_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff <= fmt_in;
         req_valid_ff <= start;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_word;
      rsp_ff <= rsp_in;
   end

   pcmsfc_convert u_convert (
      .fmt (fmt_ff),
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word = rsp_ff;

`ifndef ASSERT_OFF
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      start ##2 1'b1 |-> rsp_strobe)
      else $error("result strobe missing two cycles after start");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("result strobe without a start");
   a_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_word.channel_out == $past(req_word.channel_in, 2))
      else $error("channel not carried through");
`endif

endmodule

`default_nettype wire

// File: dv/pcm_sample_format_converter_checker.sv
// ----------------------------------------------------------------------------
// PCM sample format converter checker
// Watches the request, result and register ports, predicts each result word
// from its own model of the format conversions and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_sample_format_converter_checker
   import pcmsfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_word,
   input  logic         rsp_strobe,
   input  rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   input  logic         pready,
   output int           mismatches,
   output int           pending_samples
);

   logic [3:0]   active_format;
   rsp_word_type expected_samples[$];

   function automatic logic [63:0] round_even_shift(input logic [63:0] m, input int sh);
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) begin
         q = q + 64'd1;
      end
      return q;
   endfunction

   function automatic logic [31:0] scaled_int_to_float(input logic [31:0] v, input int scale);
      logic        sgn;
      logic [31:0] mag;
      logic [31:0] mant;
      int          p;
      sgn = v[31];
      mag = sgn ? -v : v;
      if (mag == 32'd0) begin
         return 32'd0;
      end
      p = 0;
      while (p < 31 && (mag >> (p + 1)) != 32'd0) begin
         p++;
      end
      if (p <= 23) begin
         mant = mag << (23 - p);
      end else begin
         mant = 32'(round_even_shift({32'd0, mag}, p - 23));
         if (mant == 32'h0100_0000) begin
            mant = mant >> 1;
            p++;
         end
      end
      return {sgn, 8'(p + 127 - scale), mant[22:0]};
   endfunction

   function automatic logic [31:0] double_to_single(input logic [63:0] d);
      logic        sgn;
      int          e;
      int          ef;
      logic [63:0] m;
      logic [63:0] mant;
      sgn = d[63];
      e = int'(d[62:52]);
      if (e == 2047) begin
         if (d[51:0] == 52'd0) begin
            return {sgn, 8'hff, 23'd0};
         end
         return {sgn, 9'h1ff, d[50:29]};
      end
      if (e == 0) begin
         return {sgn, 31'd0};
      end
      m = {11'd1, d[51:0]};
      ef = e - 1023 + 127;
      if (ef >= 255) begin
         return {sgn, 8'hff, 23'd0};
      end
      if (ef >= 1) begin
         mant = round_even_shift(m, 29);
         if (mant == 64'h100_0000) begin
            mant = mant >> 1;
            ef++;
         end
         if (ef >= 255) begin
            return {sgn, 8'hff, 23'd0};
         end
         return {sgn, 8'(ef), mant[22:0]};
      end
      if (30 - ef >= 64) begin
         return {sgn, 31'd0};
      end
      mant = round_even_shift(m, 30 - ef);
      return {sgn, mant[30:0]};
   endfunction

   function automatic rsp_word_type convert_sample(input logic [3:0] format,
                                                   input req_word_type w);
      rsp_word_type r;
      logic [7:0]   b0;
      logic [7:0]   b1;
      logic [7:0]   b2;
      logic [7:0]   b3;
      b0 = w.raw_word[7:0];
      b1 = w.raw_word[15:8];
      b2 = w.raw_word[23:16];
      b3 = w.raw_word[31:24];
      r = '0;
      r.channel_out = w.channel_in;
      r.last_out = w.last_in;
      case (format)
         FMT_U8: r.sample_value = {16'd0, ~b0[7], b0[6:0], 8'd0};
         FMT_I8: r.sample_value = {16'd0, b0, 8'd0};
         FMT_I16LE: r.sample_value = {16'd0, b1, b0};
         FMT_I16BE: r.sample_value = {16'd0, b0, b1};
         FMT_I24LE: r.sample_value = scaled_int_to_float({{8{b2[7]}}, b2, b1, b0}, 23);
         FMT_I24BE: r.sample_value = scaled_int_to_float({{8{b0[7]}}, b0, b1, b2}, 23);
         FMT_I32LE: r.sample_value = scaled_int_to_float({b3, b2, b1, b0}, 31);
         FMT_I32BE: r.sample_value = scaled_int_to_float({b0, b1, b2, b3}, 31);
         FMT_F32: r.sample_value = w.raw_word[31:0];
         FMT_F64: r.sample_value = double_to_single(w.raw_word);
         default: r.sample_value = 32'd0;
      endcase
      r.is_float = (format >= FMT_I24LE && format <= FMT_F64);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: sample mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   assign pending_samples = expected_samples.size();

   initial mismatches = 0;

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         active_format <= FORMAT_RESET;
         expected_samples.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == 2'(REG_FORMAT)) begin
            active_format <= pwdata[3:0];
         end
         if (start && !busy) begin
            expected_samples.push_back(convert_sample(active_format, req_word));
         end
         if (rsp_strobe) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_word));
            end else begin
               exp_w = expected_samples.pop_front();
               if (rsp_word.sample_value !== exp_w.sample_value) begin
                  report_mismatch($sformatf("sample_value %h, expected %h",
                                            rsp_word.sample_value, exp_w.sample_value));
               end
               if (rsp_word.is_float !== exp_w.is_float) begin
                  report_mismatch($sformatf("is_float %b, expected %b",
                                            rsp_word.is_float, exp_w.is_float));
               end
               if (rsp_word.channel_out !== exp_w.channel_out) begin
                  report_mismatch("channel_out differs");
               end
               if (rsp_word.last_out !== exp_w.last_out) begin
                  report_mismatch("last_out differs");
               end
            end
         end
      end
   end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// PCM sample format converter testbench
// Drives directed and random sample words through every format, rewriting
// the format register between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import pcmsfc_pkg::*;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [1:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;
   int           mismatches;
   int           pending_samples;

   pcm_sample_format_converter_top dut (.*);

   pcm_sample_format_converter_checker checker_i (.*);

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic write_format(input logic [3:0] format);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 2'(REG_FORMAT * 4);
      pwdata <= {$urandom} & 32'hffff_fff0 | {28'd0, format};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_sample(input logic [63:0] raw, input logic gaps);
      if (gaps && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= '{raw_word: raw, channel_in: 1'($urandom), last_in: 1'($urandom)};
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_samples();
      start <= 1'b0;
      while (pending_samples != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [63:0] random_sample(input logic [3:0] format);
      logic [63:0] r;
      logic [10:0] ex;
      r = {$urandom, $urandom};
      if (format == FMT_F64) begin
         case ($urandom_range(0, 5))
            0: ex = 11'h7ff;
            1: ex = 11'd0;
            2: ex = 11'(1023 - 127 - $urandom_range(0, 60));
            3: ex = 11'(1023 + 127 - $urandom_range(0, 2));
            default: ex = 11'($urandom_range(800, 1250));
         endcase
         r[62:52] = ex;
         if ($urandom_range(0, 4) == 0) begin
            r[28:0] = $urandom_range(0, 1) ? 29'h1000_0000 : 29'h0fff_ffff;
         end
      end else if ($urandom_range(0, 4) == 0) begin
         r[31:0] = $urandom_range(0, 1) ? 32'h0000_0080 : 32'h8000_0000;
         r[7:0] = 8'($urandom_range(0, 255));
      end
      return r;
   endfunction

   initial begin
      logic [63:0] directed[$];
      logic [3:0]  format;
      int          phase;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      directed = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h80, 64'h7f, 64'h0000_0000_0080_0000,
                   64'h7fff_ffff, 64'h8000_0000, 64'h0100_0001, 64'h7ff0_0000_0000_0000,
                   64'hfff8_0000_2000_0000, 64'h47ef_ffff_f000_0000, 64'h3690_0000_0000_0000,
                   64'h3680_0000_0000_0001, 64'h8000_0000_0000_0001, 64'h3ff0_0000_1000_0000,
                   64'h3ff0_0000_3000_0000, 64'h4800_0000_0000_0000, 64'h7f80_0001};
      for (int f = 0; f < 12; f++) begin
         if (f != 0) begin
            write_format(4'(f == 11 ? 15 : f));
         end
         foreach (directed[i]) begin
            send_sample(directed[i], 1'b0);
         end
         drain_samples();
      end
      for (phase = 0; phase < 24; phase++) begin
         format = (phase % 8 == 7) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
         if (phase == 22) begin
            format = FMT_F64;
         end
         if (phase == 23) begin
            format = FMT_U8;
         end
         write_format(format);
         repeat (60) begin
            send_sample(random_sample(format), phase < 20);
         end
         drain_samples();
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/pcmsfc_pkg.sv
rtl/core/pcmsfc_convert.sv
rtl/core/pcm_sample_format_converter_top.sv
dv/pcm_sample_format_converter_checker.sv
dv/tb.sv
